// File: design/cpmm_pkg.sv
package cpmm_pkg;

	// Sizes of the path store and of the item fields.
	localparam int MAX_VERTICES = 64;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int LEN_W = 16;
	localparam int SUM_W = 22;
	localparam int SEG_W = 6;
	localparam int CMP_W = (SEG_W > IDX_W) ? SEG_W : IDX_W;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH_PV,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

// File: design/cpmm_if.sv
// Edge request channel: one edge length and the end-of-path mark.
interface cpmm_in_if;
	logic                         valid;
	logic                         ready;
	logic [cpmm_pkg::LEN_W-1:0]   length;
	logic                         last;

	modport source (output valid, output length, output last, input ready);
	modport sink (input valid, input length, input last, output ready);
endinterface

// Result channel: the best minimum segment sum of one path.
interface cpmm_out_if;
	logic                         valid;
	logic                         ready;
	logic [cpmm_pkg::SUM_W-1:0]   best;

	modport source (output valid, output best, input ready);
	modport sink (input valid, input best, output ready);
endinterface

// Configuration channel: the segment count.
interface cpmm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [cpmm_pkg::SEG_W-1:0]   segments;

	modport source (output valid, output segments, input ready);
	modport sink (input valid, input segments, output ready);
endinterface

// File: design/chain_partition_max_min.sv
// Splits a path into a configured number of contiguous segments so that the
// smallest segment sum is as large as possible, and reports that sum.
// Channels: edges takes one edge length per request, with last marking the
// final edge of a path; result returns one best value per path; cfg writes
// the segment count (0 to 63, 1 after reset) and is always ready.
// Loading accepts one edge request per cycle. After the last edge the block
// stops taking edges and runs a layered dynamic program out of two on-chip
// memories (prefix sums, and a two-bank row store). For each layer j from 2
// to the segment count and each vertex v from j to the edge count E, it
// fetches prefix[v], visits each split point in turn, and writes the row
// entry, then hands the final value to the output register. Trivial cases
// (at most one segment, or segments not fewer than vertices) go from the
// last edge straight to the finish state. Edges beyond 63 per path are
// dropped. Reset clears the sequencer, the edge count and the output valid
// flag; the memories need no clearing since only written entries are ever
// read. While the receiver stalls, the finished value waits in the output
// register and the next path loads; the next solve result waits until it is taken.
module chain_partition_max_min (
	input  logic              clk,
	input  logic              arst_n,
	cpmm_in_if.sink           edges,
	cpmm_out_if.source        result,
	cpmm_cfg_if.sink          cfg
);

	cpmm_pkg::state_t state_q, state_d;

	logic [cpmm_pkg::SEG_W-1:0] segments_q;
	logic [cpmm_pkg::IDX_W-1:0] ecnt_q;
	logic [cpmm_pkg::SUM_W-1:0] sum_q;
	logic [cpmm_pkg::SEG_W-1:0] j_q;
	logic [cpmm_pkg::IDX_W-1:0] v_q;
	logic [cpmm_pkg::IDX_W-1:0] k_q;
	logic [cpmm_pkg::SUM_W-1:0] pv_q;
	logic [cpmm_pkg::SUM_W-1:0] acc_q;
	logic [cpmm_pkg::SUM_W-1:0] res_q;
	logic                       rd_s1;
	logic                       pv_s1;
	logic                       out_valid_q;
	logic [cpmm_pkg::SUM_W-1:0] out_best_q;

	// Memories and their registered read data.
	logic [cpmm_pkg::SUM_W-1:0] prefix_mem [cpmm_pkg::MAX_VERTICES];
	logic [cpmm_pkg::SUM_W-1:0] row_mem [2*cpmm_pkg::MAX_VERTICES];
	logic [cpmm_pkg::SUM_W-1:0] pf_rdata_q;
	logic [cpmm_pkg::SUM_W-1:0] row_rdata_q;

	logic                       in_fire;
	logic                       full;
	logic [cpmm_pkg::IDX_W-1:0] ecnt_new;
	logic [cpmm_pkg::SUM_W-1:0] sum_new;
	logic                       trivial;
	logic [cpmm_pkg::SUM_W-1:0] trivial_val;
	logic                       v_end;
	logic                       j_end;
	logic                       k_end;
	logic                       out_free;
	logic [cpmm_pkg::SUM_W-1:0] tail;
	logic [cpmm_pkg::SUM_W-1:0] prev_val;
	logic [cpmm_pkg::SUM_W-1:0] cand;
	logic [cpmm_pkg::SUM_W-1:0] acc_next;
	logic [cpmm_pkg::IDX_W-1:0] pf_raddr;
	logic                       pf_we;
	logic                       row_we;

	// Load arithmetic: the new prefix sum and the trivial-answer check.
	always_comb begin
		full        = (ecnt_q == cpmm_pkg::IDX_W'(cpmm_pkg::MAX_VERTICES - 1));
		ecnt_new    = full ? ecnt_q : ecnt_q + cpmm_pkg::IDX_W'(1);
		sum_new     = full ? sum_q : sum_q + cpmm_pkg::SUM_W'(edges.length);
		trivial     = (segments_q <= cpmm_pkg::SEG_W'(1)) ||
			(cpmm_pkg::CMP_W'(segments_q) > cpmm_pkg::CMP_W'(ecnt_new));
		trivial_val = (segments_q == cpmm_pkg::SEG_W'(1) && !(
			cpmm_pkg::CMP_W'(segments_q) > cpmm_pkg::CMP_W'(ecnt_new))) ?
			sum_new : '0;
	end

	// Loop bounds of the dynamic program.
	always_comb begin
		v_end    = (v_q == ecnt_q);
		j_end    = (j_q == segments_q);
		k_end    = (k_q == v_q - cpmm_pkg::IDX_W'(1));
		out_free = !out_valid_q || result.ready;
	end

	// One split point: the tail segment against the best of the layer below.
	// Layer two takes the prefix sums themselves as its lower layer.
	always_comb begin
		tail     = pv_q - pf_rdata_q;
		prev_val = (j_q == cpmm_pkg::SEG_W'(2)) ? pf_rdata_q : row_rdata_q;
		cand     = (prev_val < tail) ? prev_val : tail;
		acc_next = (cand > acc_q) ? cand : acc_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpmm_pkg::ST_LOAD: begin
				if (in_fire && edges.last) begin
					state_d = trivial ? cpmm_pkg::ST_FINISH : cpmm_pkg::ST_FETCH_PV;
				end
			end
			cpmm_pkg::ST_FETCH_PV: begin
				state_d = cpmm_pkg::ST_SWEEP;
			end
			cpmm_pkg::ST_SWEEP: begin
				if (k_end) begin
					state_d = cpmm_pkg::ST_DRAIN;
				end
			end
			cpmm_pkg::ST_DRAIN: begin
				if (v_end && j_end) begin
					state_d = cpmm_pkg::ST_FINISH;
				end else begin
					state_d = cpmm_pkg::ST_FETCH_PV;
				end
			end
			cpmm_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = cpmm_pkg::ST_LOAD;
				end
			end
			default: state_d = cpmm_pkg::ST_LOAD;
		endcase
	end

	// Handshakes and memory strobes.
	always_comb begin
		edges.ready  = (state_q == cpmm_pkg::ST_LOAD);
		in_fire      = edges.valid && edges.ready;
		pf_we        = in_fire && !full;
		row_we       = (state_q == cpmm_pkg::ST_DRAIN);
		pf_raddr     = (state_q == cpmm_pkg::ST_FETCH_PV) ? v_q : k_q;
		cfg.ready    = 1'b1;
		result.valid = out_valid_q;
		result.best  = out_best_q;
	end

	// Prefix sums: written while loading, read during the solve, never both.
	always_ff @(posedge clk) begin
		if (pf_we) begin
			prefix_mem[ecnt_new] <= sum_new;
		end
		pf_rdata_q <= prefix_mem[pf_raddr];
	end

	// Row store: layer j writes bank j[0] and reads the other bank, so a
	// write never meets a read of the same entry.
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[{j_q[0], v_q}] <= acc_next;
		end
		row_rdata_q <= row_mem[{~j_q[0], k_q}];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpmm_pkg::ST_LOAD;
			segments_q  <= cpmm_pkg::SEG_W'(1);
			ecnt_q      <= '0;
			sum_q       <= '0;
			rd_s1       <= 1'b0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= (state_q == cpmm_pkg::ST_SWEEP);
			pv_s1   <= (state_q == cpmm_pkg::ST_FETCH_PV);
			if (cfg.valid && cfg.ready) begin
				segments_q <= cfg.segments;
			end
			if (pf_we) begin
				ecnt_q <= ecnt_new;
				sum_q  <= sum_new;
			end
			if (state_q == cpmm_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
				ecnt_q      <= '0;
				sum_q       <= '0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Loop counters, accumulator and the result value.
	always_ff @(posedge clk) begin
		if (pv_s1) begin
			pv_q <= pf_rdata_q;
		end
		if (state_q == cpmm_pkg::ST_FETCH_PV) begin
			acc_q <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_next;
		end
		if (state_q == cpmm_pkg::ST_FINISH && out_free) begin
			out_best_q <= res_q;
		end
		unique case (state_q) inside
			cpmm_pkg::ST_LOAD: begin
				if (in_fire && edges.last) begin
					res_q <= trivial_val;
					j_q   <= cpmm_pkg::SEG_W'(2);
					v_q   <= cpmm_pkg::IDX_W'(2);
					k_q   <= cpmm_pkg::IDX_W'(1);
				end
			end
			cpmm_pkg::ST_SWEEP: begin
				k_q <= k_q + cpmm_pkg::IDX_W'(1);
			end
			cpmm_pkg::ST_DRAIN: begin
				if (v_end) begin
					if (j_end) begin
						res_q <= acc_next;
					end else begin
						j_q <= j_q + cpmm_pkg::SEG_W'(1);
						v_q <= cpmm_pkg::IDX_W'(j_q) + cpmm_pkg::IDX_W'(1);
						k_q <= cpmm_pkg::IDX_W'(j_q);
					end
				end else begin
					v_q <= v_q + cpmm_pkg::IDX_W'(1);
					k_q <= cpmm_pkg::IDX_W'(j_q) - cpmm_pkg::IDX_W'(1);
				end
			end
			cpmm_pkg::ST_FETCH_PV, cpmm_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

endmodule
